/* rtl/core/bht_pkg.sv */
`timescale 1ns / 1ps
// bht_pkg: shared widths, operation and status codes, and controller states
// for the bucketed hash table core. No dependencies.
package bht_pkg;

  localparam int OP_W  = 2;
  localparam int KEY_W = 31;
  localparam int PAY_W = 32;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_DUP     = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FILL_RD,
    S_FILL_LATCH,
    S_PROBE,
    S_CHECK,
    S_RESOLVE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

/* rtl/core/bht_mod_unit.sv */
`timescale 1ns / 1ps
// bht_mod_unit: bucket index = key mod BUCKETS; a power-of-two bucket count is a mask,
// otherwise a reciprocal multiply, registered, then a multiply-back subtract.
// Depends on bht_pkg.
module bht_mod_unit #(
  parameter int BUCKETS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bht_pkg::KEY_W-1:0]    key_in,
  output logic                         done,
  output logic [$clog2(BUCKETS)-1:0]   rem
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int SH    = bht_pkg::KEY_W + BW;
  localparam int PW    = bht_pkg::KEY_W + 32;
  localparam bit Pow2  = (BUCKETS & (BUCKETS - 1)) == 0;
  // ceil(2^SH / BUCKETS), the high product bits are then the exact quotient for any key
  localparam logic [31:0] Recip =
    32'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [bht_pkg::KEY_W-1:0] Divisor = bht_pkg::KEY_W'(BUCKETS);

  logic                      busy;
  logic [bht_pkg::KEY_W-1:0] key_q;
  logic [PW-1:0]             prod;
  logic [bht_pkg::KEY_W-1:0] quo;
  logic [bht_pkg::KEY_W-1:0] back;

  assign quo  = bht_pkg::KEY_W'(prod >> SH);
  assign back = quo * Divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      rem   <= '0;
      key_q <= '0;
      prod  <= '0;
    end else begin
      done <= 1'b0;
      busy <= 1'b0;
      if (start) begin
        if (Pow2) begin
          rem  <= key_in[BW-1:0];
          done <= 1'b1;
        end else begin
          key_q <= key_in;
          prod  <= PW'(key_in) * PW'(Recip);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem  <= BW'(key_q - back);
        done <= 1'b1;
      end
    end
  end

endmodule

/* rtl/core/bucketed_hash_table_core.sv */
`timescale 1ns / 1ps
// bucketed_hash_table_core: keyed table of BUCKETS buckets with SLOTS ordered slots each.
// Steps: S_HASH, S_FILL_RD, S_FILL_LATCH, S_PROBE/S_CHECK per slot compared, S_RESOLVE,
// S_SHIFT_RD/S_SHIFT_WR per slot shifted, S_DONE; S_HASH waits longer if BUCKETS is not a
// power of 2. Probing and shifting go one slot at a time through the slot memory.
// One item at a time: in_ready is high only while idle, once the last result is registered.
// After reset a clearing pass zeroes every bucket's fill count; in_ready stays low.
module bucketed_hash_table_core #(
  parameter int BUCKETS    = 16,
  parameter int SLOTS      = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bht_pkg::OP_W-1:0]      op,
  input  logic [bht_pkg::KEY_W-1:0]     key,
  input  logic [bht_pkg::PAY_W-1:0]     payload,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bht_pkg::ST_W-1:0]      status,
  output logic [bht_pkg::PAY_W-1:0]     found_payload,
  output logic [$clog2(SLOTS+1)-1:0]    bucket_fill
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int FW    = $clog2(SLOTS + 1);
  localparam int DEPTH = BUCKETS * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [FW-1:0] FullFill = FW'(SLOTS);
  localparam logic [BW-1:0] LastBucket = BW'(BUCKETS - 1);

  bht_pkg::state_t state, state_next;

  // slot and fill memories
  logic [bht_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [DATA_WIDTH-1:0]     pay_mem [DEPTH];
  logic [FW-1:0]             fill_mem [BUCKETS];

  logic [bht_pkg::KEY_W-1:0] key_rd;
  logic [DATA_WIDTH-1:0]     pay_rd;
  logic [FW-1:0]             fill_rd;

  logic                      kv_we;
  logic [AW-1:0]             kv_waddr;
  logic [AW-1:0]             kv_raddr;
  logic [bht_pkg::KEY_W-1:0] kv_wkey;
  logic [DATA_WIDTH-1:0]     kv_wpay;
  logic                      fill_we;
  logic [FW-1:0]             fill_wdata;

  // item registers
  logic [bht_pkg::OP_W-1:0]  op_q;
  logic [bht_pkg::KEY_W-1:0] key_q;
  logic [DATA_WIDTH-1:0]     pay_q;
  logic [BW-1:0]             bucket;
  logic [AW-1:0]             base;
  logic [FW-1:0]             fill;
  logic [FW-1:0]             slot;
  logic                      hit;
  logic [DATA_WIDTH-1:0]     found;
  logic [bht_pkg::ST_W-1:0]  status_q;
  logic [FW-1:0]             fill_q;

  // resolve decision
  logic [bht_pkg::ST_W-1:0]  res_status;
  logic [FW-1:0]             res_fill;
  logic                      res_store;
  logic                      res_fill_we;
  logic                      res_shift;

  logic                      in_xfer;
  logic                      out_free;
  logic                      mod_start;
  logic                      mod_done;
  logic [BW-1:0]             mod_rem;
  logic                      shift_more;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign shift_more = ((FW + 1)'(slot) + (FW + 1)'(2)) < (FW + 1)'(fill);

  bht_mod_unit #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .key_in (key),
    .done   (mod_done),
    .rem    (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[kv_waddr] <= kv_wkey;
      pay_mem[kv_waddr] <= kv_wpay;
    end
    key_rd <= key_mem[kv_raddr];
    pay_rd <= pay_mem[kv_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[bucket] <= fill_wdata;
    end
    fill_rd <= fill_mem[bucket];
  end

  always_comb begin
    res_status  = bht_pkg::ST_OK;
    res_fill    = fill;
    res_store   = 1'b0;
    res_fill_we = 1'b0;
    res_shift   = 1'b0;
    unique case (op_q)
      bht_pkg::OP_INSERT: begin
        if (hit) begin
          res_status = bht_pkg::ST_DUP;
        end else if (fill == FullFill) begin
          res_status = bht_pkg::ST_FULL;
        end else begin
          res_fill    = fill + FW'(1);
          res_store   = 1'b1;
          res_fill_we = 1'b1;
        end
      end
      bht_pkg::OP_REMOVE: begin
        if (!hit) begin
          res_status = bht_pkg::ST_MISSING;
        end else begin
          res_fill    = fill - FW'(1);
          res_fill_we = 1'b1;
          res_shift   = ((FW + 1)'(slot) + (FW + 1)'(1)) < (FW + 1)'(fill);
        end
      end
      default: begin
        if (!hit) begin
          res_status = bht_pkg::ST_MISSING;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bht_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bht_pkg::S_CLEAR: begin
        if (bucket == LastBucket) state_next = bht_pkg::S_IDLE;
      end
      bht_pkg::S_IDLE: begin
        if (in_xfer) state_next = bht_pkg::S_HASH;
      end
      bht_pkg::S_HASH: begin
        if (mod_done) state_next = bht_pkg::S_FILL_RD;
      end
      bht_pkg::S_FILL_RD:    state_next = bht_pkg::S_FILL_LATCH;
      bht_pkg::S_FILL_LATCH: state_next = bht_pkg::S_PROBE;
      bht_pkg::S_PROBE: begin
        if (slot == fill) begin
          state_next = bht_pkg::S_RESOLVE;
        end else begin
          state_next = bht_pkg::S_CHECK;
        end
      end
      bht_pkg::S_CHECK: begin
        if (key_rd == key_q) begin
          state_next = bht_pkg::S_RESOLVE;
        end else begin
          state_next = bht_pkg::S_PROBE;
        end
      end
      bht_pkg::S_RESOLVE: begin
        if (res_shift) begin
          state_next = bht_pkg::S_SHIFT_RD;
        end else begin
          state_next = bht_pkg::S_DONE;
        end
      end
      bht_pkg::S_SHIFT_RD: state_next = bht_pkg::S_SHIFT_WR;
      bht_pkg::S_SHIFT_WR: begin
        if (shift_more) begin
          state_next = bht_pkg::S_SHIFT_RD;
        end else begin
          state_next = bht_pkg::S_DONE;
        end
      end
      bht_pkg::S_DONE: begin
        if (out_free) state_next = bht_pkg::S_IDLE;
      end
      default: state_next = bht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    mod_start  = 1'b0;
    kv_we      = 1'b0;
    kv_waddr   = base + AW'(slot);
    kv_raddr   = base + AW'(slot);
    kv_wkey    = key_rd;
    kv_wpay    = pay_rd;
    fill_we    = 1'b0;
    fill_wdata = res_fill;
    unique case (state)
      bht_pkg::S_CLEAR: begin
        fill_we    = 1'b1;
        fill_wdata = '0;
      end
      bht_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        mod_start = in_valid;
      end
      bht_pkg::S_RESOLVE: begin
        kv_we    = res_store;
        kv_waddr = base + AW'(fill);
        kv_wkey  = key_q;
        kv_wpay  = pay_q;
        fill_we  = res_fill_we;
      end
      bht_pkg::S_SHIFT_RD: begin
        kv_raddr = base + AW'(slot) + AW'(1);
      end
      bht_pkg::S_SHIFT_WR: begin
        kv_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        bht_pkg::S_CLEAR: begin
          bucket <= bucket + BW'(1);
        end
        bht_pkg::S_HASH: begin
          if (mod_done) bucket <= mod_rem;
        end
        bht_pkg::S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      bht_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_q  <= op;
          key_q <= key;
          pay_q <= DATA_WIDTH'(payload);
        end
      end
      bht_pkg::S_FILL_RD: begin
        base <= AW'(bucket * SLOTS);
      end
      bht_pkg::S_FILL_LATCH: begin
        fill <= fill_rd;
        slot <= '0;
        hit  <= 1'b0;
      end
      bht_pkg::S_CHECK: begin
        if (key_rd == key_q) begin
          hit   <= 1'b1;
          found <= pay_rd;
        end else begin
          slot <= slot + FW'(1);
        end
      end
      bht_pkg::S_RESOLVE: begin
        status_q <= res_status;
        fill_q   <= res_fill;
      end
      bht_pkg::S_SHIFT_WR: begin
        slot <= slot + FW'(1);
      end
      bht_pkg::S_DONE: begin
        if (out_free) begin
          status      <= status_q;
          bucket_fill <= fill_q;
          if (hit && op_q != bht_pkg::OP_INSERT) begin
            found_payload <= bht_pkg::PAY_W'(found);
          end else begin
            found_payload <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bucket_fill <= FullFill)
    else $error("reported bucket fill exceeds slot count");

  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bht_pkg::ST_FULL |-> bucket_fill == FullFill)
    else $error("bucket full reported with a free slot");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bht_pkg::ST_OK |-> found_payload == '0)
    else $error("failed operation returned a payload");

  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == bht_pkg::S_HASH)
    else $error("bucket index finished outside the hash step");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for bucketed_hash_table_core, directed table then pooled random ops.
// Depends on bht_pkg and the core; keeps its own shadow of the buckets to predict each result.
module tb;

  localparam int BUCKETS = 16;
  localparam int SLOTS = 4;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int RAND_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT = 31;
  localparam int CALM_FROM = 600;
  localparam int CALM_TO = 900;
  localparam logic [bht_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic [bht_pkg::KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;
  localparam logic [bht_pkg::PAY_W-1:0] PAY_ONES = 32'hFFFF_FFFF;
  localparam logic [bht_pkg::PAY_W-1:0] PAY_JUNK = 32'hDEAD_BEEF;

  typedef struct packed {
    logic [bht_pkg::OP_W-1:0]  op;
    logic [bht_pkg::KEY_W-1:0] key;
    logic [bht_pkg::PAY_W-1:0] pay;
    logic                      typed;
    logic [bht_pkg::ST_W-1:0]  st;
    logic [bht_pkg::PAY_W-1:0] found;
    logic [FILL_W-1:0]         fill;
  } stim_row_t;

  typedef struct packed {
    logic [bht_pkg::ST_W-1:0]  st;
    logic [bht_pkg::PAY_W-1:0] found;
    logic [FILL_W-1:0]         fill;
  } result_t;

  // typed rows carry their result, the others go through the shadow predictor
  localparam int DIR_N = 25;
  localparam stim_row_t DIR_ROWS [0:DIR_N-1] = '{
    '{bht_pkg::OP_LOOKUP, 31'd0,        PAY_JUNK,     1'b1, bht_pkg::ST_MISSING, 32'd0, 3'd0},
    '{bht_pkg::OP_REMOVE, KEY_MAX,      PAY_JUNK,     1'b1, bht_pkg::ST_MISSING, 32'd0, 3'd0},
    '{bht_pkg::OP_INSERT, 31'd5,        PAY_ONES,     1'b1, bht_pkg::ST_OK,      32'd0, 3'd1},
    '{bht_pkg::OP_INSERT, 31'd21,       32'd0,        1'b1, bht_pkg::ST_OK,      32'd0, 3'd2},
    '{bht_pkg::OP_INSERT, 31'd37,       32'hA5A5A5A5, 1'b1, bht_pkg::ST_OK,      32'd0, 3'd3},
    '{bht_pkg::OP_INSERT, 31'h7FFFFFF5, 32'h5A5A5A5A, 1'b1, bht_pkg::ST_OK,      32'd0, 3'd4},
    '{bht_pkg::OP_INSERT, 31'd53,       32'h00001234, 1'b1, bht_pkg::ST_FULL,    32'd0, 3'd4},
    '{bht_pkg::OP_INSERT, 31'd21,       32'h00000077, 1'b1, bht_pkg::ST_DUP,     32'd0, 3'd4},
    '{bht_pkg::OP_LOOKUP, 31'h7FFFFFF5, PAY_JUNK,     1'b1, bht_pkg::ST_OK,
      32'h5A5A5A5A, 3'd4},
    '{bht_pkg::OP_LOOKUP, 31'd53,       PAY_JUNK,     1'b1, bht_pkg::ST_MISSING, 32'd0, 3'd4},
    '{bht_pkg::OP_REMOVE, 31'd5,        PAY_JUNK,     1'b1, bht_pkg::ST_OK,   PAY_ONES, 3'd3},
    '{OP_RESERVED,        31'd37,       PAY_JUNK,     1'b0, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_INSERT, 31'd53,       32'h00001234, 1'b0, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_REMOVE, 31'h7FFFFFF5, PAY_JUNK,     1'b0, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_REMOVE, 31'd53,       PAY_JUNK,     1'b0, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_REMOVE, 31'd21,       PAY_JUNK,     1'b0, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_REMOVE, 31'd37,       PAY_JUNK,     1'b0, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_INSERT, 31'd5,        32'd0,        1'b0, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_LOOKUP, 31'd5,        PAY_ONES,     1'b0, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_INSERT, KEY_MAX,      PAY_ONES,     1'b1, bht_pkg::ST_OK,      32'd0, 3'd1},
    '{OP_RESERVED,        KEY_MAX,      32'd0,        1'b1, bht_pkg::ST_OK,   PAY_ONES, 3'd1},
    '{bht_pkg::OP_REMOVE, 31'd15,       PAY_JUNK,     1'b1, bht_pkg::ST_MISSING, 32'd0, 3'd1},
    '{bht_pkg::OP_INSERT, 31'd0,        32'd0,        1'b1, bht_pkg::ST_OK,      32'd0, 3'd1},
    '{bht_pkg::OP_REMOVE, 31'd0,        PAY_ONES,     1'b1, bht_pkg::ST_OK,      32'd0, 3'd0},
    '{bht_pkg::OP_REMOVE, KEY_MAX,      32'd0,        1'b1, bht_pkg::ST_OK,   PAY_ONES, 3'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [bht_pkg::OP_W-1:0] op = '0;
  logic [bht_pkg::KEY_W-1:0] key = '0;
  logic [bht_pkg::PAY_W-1:0] payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [bht_pkg::ST_W-1:0] status;
  logic [bht_pkg::PAY_W-1:0] found_payload;
  logic [FILL_W-1:0] bucket_fill;

  stim_row_t stim_q[$];
  stim_row_t cur_row = '0;
  result_t pending_results[$];

  logic [bht_pkg::KEY_W-1:0] shadow_keys [BUCKETS][SLOTS];
  logic [bht_pkg::PAY_W-1:0] shadow_pays [BUCKETS][SLOTS];
  int shadow_fill [BUCKETS];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int sent_cnt = 0;
  int taken_cnt = 0;
  int done_cnt = 0;
  int status_seen [4];

  bucketed_hash_table_core #(
    .BUCKETS(BUCKETS),
    .SLOTS(SLOTS),
    .DATA_WIDTH(bht_pkg::PAY_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .key(key),
    .payload(payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_payload(found_payload),
    .bucket_fill(bucket_fill)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // applies one op to the shadow buckets and returns the result the core owes
  function automatic result_t hash_bucket_step(input logic [bht_pkg::OP_W-1:0] op_i,
                                               input logic [bht_pkg::KEY_W-1:0] key_i,
                                               input logic [bht_pkg::PAY_W-1:0] pay_i);
    result_t r;
    int b;
    int n;
    int hit;
    r = '0;
    b = key_i % BUCKETS;
    n = shadow_fill[b];
    hit = -1;
    for (int s = 0; s < n; s++) begin
      if (shadow_keys[b][s] == key_i) hit = s;
    end
    if (op_i == bht_pkg::OP_INSERT) begin
      if (hit >= 0) begin
        r.st = bht_pkg::ST_DUP;
      end else if (n >= SLOTS) begin
        r.st = bht_pkg::ST_FULL;
      end else begin
        shadow_keys[b][n] = key_i;
        shadow_pays[b][n] = pay_i;
        n++;
      end
    end else if (op_i == bht_pkg::OP_REMOVE) begin
      if (hit < 0) begin
        r.st = bht_pkg::ST_MISSING;
      end else begin
        r.found = shadow_pays[b][hit];
        for (int s = hit; s + 1 < n; s++) begin
          shadow_keys[b][s] = shadow_keys[b][s + 1];
          shadow_pays[b][s] = shadow_pays[b][s + 1];
        end
        n--;
      end
    end else begin
      // reserved op behaves as lookup
      if (hit < 0) r.st = bht_pkg::ST_MISSING;
      else r.found = shadow_pays[b][hit];
    end
    shadow_fill[b] = n;
    r.fill = n[FILL_W-1:0];
    return r;
  endfunction

  // random ops on pools of keys crowded into a few buckets, with some stray keys
  task automatic build_random_stim();
    logic [bht_pkg::KEY_W-1:0] pool [32];
    logic [3:0] hot [6];
    stim_row_t row;
    int pool_n;
    int hot_n;
    int left;
    int pick;
    left = RAND_ITEMS;
    while (left > 0) begin
      hot_n = $urandom_range(1, 6);
      for (int i = 0; i < hot_n; i++) hot[i] = 4'($urandom_range(0, BUCKETS - 1));
      pool_n = $urandom_range(5, 32);
      for (int i = 0; i < pool_n; i++) begin
        pool[i] = {27'($urandom_range(0, (1 << 27) - 1)), hot[$urandom_range(0, hot_n - 1)]};
      end
      for (int i = 0; i < 100 && left > 0; i++) begin
        row = '0;
        row.pay = $urandom();
        if ($urandom_range(0, 99) < 8) begin
          row.op = bht_pkg::OP_W'($urandom_range(0, 3));
          row.key = bht_pkg::KEY_W'($urandom());
        end else begin
          row.key = pool[$urandom_range(0, pool_n - 1)];
          pick = $urandom_range(0, 99);
          if (pick < 40) row.op = bht_pkg::OP_INSERT;
          else if (pick < 68) row.op = bht_pkg::OP_REMOVE;
          else if (pick < 95) row.op = bht_pkg::OP_LOOKUP;
          else row.op = OP_RESERVED;
        end
        stim_q.push_back(row);
        left--;
      end
    end
  endtask

  // input side: a new item only after the previous one transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (stim_q.size() != 0 &&
          ((sent_cnt >= CALM_FROM && sent_cnt < CALM_TO) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        op <= stim_q[0].op;
        key <= stim_q[0].key;
        payload <= stim_q[0].pay;
        cur_row <= stim_q[0];
        void'(stim_q.pop_front());
        sent_cnt++;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken_cnt++;
      out_ready <= (taken_cnt >= CALM_FROM && taken_cnt < CALM_TO) ||
                   $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    result_t predicted;
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predicted = hash_bucket_step(cur_row.op, cur_row.key, cur_row.pay);
        if (cur_row.typed) pending_results.push_back({cur_row.st, cur_row.found, cur_row.fill});
        else pending_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        done_cnt++;
        status_seen[status]++;
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: st=%0d pay=%h fill=%0d",
                                      status, found_payload, bucket_fill);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st || found_payload !== want.found ||
              bucket_fill !== want.fill) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result %0d mismatch: exp st=%0d pay=%h fill=%0d, got st=%0d pay=%h fill=%0d",
                       done_cnt, want.st, want.found, want.fill,
                       status, found_payload, bucket_fill);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int b = 0; b < BUCKETS; b++) shadow_fill[b] = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < DIR_N; i++) stim_q.push_back(DIR_ROWS[i]);
    build_random_stim();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) err_cnt++;
    $display("%0d transfers checked: ok %0d, bucket full %0d, duplicate %0d, missing %0d",
             done_cnt, status_seen[bht_pkg::ST_OK], status_seen[bht_pkg::ST_FULL],
             status_seen[bht_pkg::ST_DUP], status_seen[bht_pkg::ST_MISSING]);
    $display("%0d mismatches, %0d results never delivered", err_cnt, pending_results.size());
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
